FILE: rtl/frc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and constants for the FIFO replacement cache unit.
// ----------------------------------------------------------------------------
package frc_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int ID_W            = 32;
   localparam int CAP_W           = 5;
   localparam int CSR_ADDR_W      = 2;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY_ADDR = '0;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   localparam logic ACT_ACCESS = 1'b0;
   localparam logic ACT_DUMP   = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } frc_state_type;

   typedef struct packed {
      logic access;
      logic dump_start;
      logic dump_emit;
   } frc_cmd_type;

   typedef struct packed {
      logic out_free;
      logic fill_zero;
      logic dump_last;
   } frc_status_type;

endpackage

FILE: rtl/frc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_ctrl
// Sequencer that accepts requests and steps the datapath through dumps.
// ----------------------------------------------------------------------------
module frc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_action,
   input  frc_pkg::frc_status_type status,
   output frc_pkg::frc_cmd_type    cmd
);
   import frc_pkg::*;

   frc_state_type state_ff;
   frc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               if (req_action == ACT_ACCESS) begin
                  cmd.access = 1'b1;
               end else begin
                  cmd.dump_start = 1'b1;
                  if (!status.fill_zero) begin
                     state_in = ST_DUMP;
                  end
               end
            end
         end
         ST_DUMP: begin
            if (status.out_free) begin
               cmd.dump_emit = 1'b1;
               if (status.dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/frc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_datapath
// Entry store with parallel lookup, FIFO pointers, capacity register and
// result register.
// ----------------------------------------------------------------------------
module frc_datapath #(
   parameter int MAX_ENTRIES = frc_pkg::MAX_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [frc_pkg::ID_W-1:0]      req_friend_id,
   input  frc_pkg::frc_cmd_type          cmd,
   output frc_pkg::frc_status_type       status,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic                          rsp_evicted_valid,
   output logic [frc_pkg::ID_W-1:0]      rsp_evicted_id,
   output logic                          rsp_entry_valid,
   output logic [frc_pkg::ID_W-1:0]      rsp_entry_id,
   output logic [frc_pkg::CAP_W-1:0]     rsp_held_count,
   output logic                          rsp_last_of_run,
   input  logic                          cfg_write,
   input  logic [frc_pkg::CAP_W-1:0]     cfg_wdata,
   output logic [frc_pkg::CAP_W-1:0]     cfg_capacity
);
   import frc_pkg::*;

   localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [ID_W-1:0]   entry_ff [MAX_ENTRIES];
   logic [SLOT_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  dump_cnt_ff, dump_cnt_in;
   logic [CAP_W-1:0]  capacity_ff, capacity_in;

   logic              valid_ff, valid_in;
   logic              hit_ff, hit_in;
   logic              ev_valid_ff, ev_valid_in;
   logic [ID_W-1:0]   ev_id_ff, ev_id_in;
   logic              en_valid_ff, en_valid_in;
   logic [ID_W-1:0]   en_id_ff, en_id_in;
   logic [CAP_W-1:0]  count_ff, count_in;
   logic              last_ff, last_in;

   logic [SUM_W-1:0]  age [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] match;
   logic              hit;
   logic              full;
   logic [CMP_W-1:0]  cap_ext, cap_eff;
   logic [SUM_W-1:0]  ins_sum, next_sum, dump_sum;
   logic [SLOT_W-1:0] ins_slot, next_slot, dump_slot, rd_slot;
   logic [ID_W-1:0]   rd_data;
   logic              wr_en;
   logic              load;

   // Parallel lookup over the live entries.
   always_comb begin
      for (int s = 0; s < MAX_ENTRIES; s++) begin
         age[s] = (SUM_W'(s) >= SUM_W'(oldest_ff))
                ? SUM_W'(s) - SUM_W'(oldest_ff)
                : SUM_W'(s) + SUM_W'(MAX_ENTRIES) - SUM_W'(oldest_ff);
         match[s] = (age[s] < SUM_W'(fill_ff)) && (entry_ff[s] == req_friend_id);
      end
   end

   assign hit = |match;

   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         cap_eff = CMP_W'(MAX_ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end

   assign full = (CMP_W'(fill_ff) >= cap_eff);

   always_comb begin
      ins_sum   = SUM_W'(oldest_ff) + SUM_W'(fill_ff);
      next_sum  = SUM_W'(oldest_ff) + SUM_W'(1);
      dump_sum  = SUM_W'(oldest_ff) + SUM_W'(dump_cnt_ff) - SUM_W'(1);
      ins_slot  = (ins_sum >= SUM_W'(MAX_ENTRIES))
                ? SLOT_W'(ins_sum - SUM_W'(MAX_ENTRIES)) : SLOT_W'(ins_sum);
      next_slot = (next_sum >= SUM_W'(MAX_ENTRIES))
                ? SLOT_W'(next_sum - SUM_W'(MAX_ENTRIES)) : SLOT_W'(next_sum);
      dump_slot = (dump_sum >= SUM_W'(MAX_ENTRIES))
                ? SLOT_W'(dump_sum - SUM_W'(MAX_ENTRIES)) : SLOT_W'(dump_sum);
      rd_slot   = cmd.dump_emit ? dump_slot : oldest_ff;
   end

   assign rd_data = entry_ff[rd_slot];
   assign wr_en   = cmd.access && !hit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[ins_slot] <= req_friend_id;
      end
   end

   always_comb begin
      oldest_in   = oldest_ff;
      fill_in     = fill_ff;
      dump_cnt_in = dump_cnt_ff;
      hit_in      = hit_ff;
      ev_valid_in = ev_valid_ff;
      ev_id_in    = ev_id_ff;
      en_valid_in = en_valid_ff;
      en_id_in    = en_id_ff;
      count_in    = count_ff;
      last_in     = last_ff;
      load        = 1'b0;

      if (cmd.access) begin
         load        = 1'b1;
         hit_in      = hit;
         ev_valid_in = 1'b0;
         ev_id_in    = '0;
         en_valid_in = 1'b0;
         en_id_in    = '0;
         last_in     = 1'b1;
         count_in    = CAP_W'(fill_ff);
         if (!hit) begin
            if (full) begin
               ev_valid_in = 1'b1;
               ev_id_in    = rd_data;
               oldest_in   = next_slot;
            end else begin
               fill_in  = fill_ff + CNT_W'(1);
               count_in = CAP_W'(fill_ff + CNT_W'(1));
            end
         end
      end else if (cmd.dump_start) begin
         dump_cnt_in = fill_ff;
         if (fill_ff == '0) begin
            load        = 1'b1;
            hit_in      = 1'b0;
            ev_valid_in = 1'b0;
            ev_id_in    = '0;
            en_valid_in = 1'b0;
            en_id_in    = '0;
            count_in    = '0;
            last_in     = 1'b1;
            oldest_in   = '0;
         end
      end else if (cmd.dump_emit) begin
         load        = 1'b1;
         hit_in      = 1'b0;
         ev_valid_in = 1'b0;
         ev_id_in    = '0;
         en_valid_in = 1'b1;
         en_id_in    = rd_data;
         count_in    = CAP_W'(fill_ff);
         last_in     = (dump_cnt_ff == CNT_W'(1));
         dump_cnt_in = dump_cnt_ff - CNT_W'(1);
         if (dump_cnt_ff == CNT_W'(1)) begin
            fill_in   = '0;
            oldest_in = '0;
         end
      end

      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   assign capacity_in = cfg_write ? cfg_wdata : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff   <= '0;
         fill_ff     <= '0;
         dump_cnt_ff <= '0;
         capacity_ff <= CAPACITY_RESET;
         valid_ff    <= 1'b0;
      end else begin
         oldest_ff   <= oldest_in;
         fill_ff     <= fill_in;
         dump_cnt_ff <= dump_cnt_in;
         capacity_ff <= capacity_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff      <= hit_in;
      ev_valid_ff <= ev_valid_in;
      ev_id_ff    <= ev_id_in;
      en_valid_ff <= en_valid_in;
      en_id_ff    <= en_id_in;
      count_ff    <= count_in;
      last_ff     <= last_in;
   end

   assign status.out_free  = !valid_ff || rsp_ready;
   assign status.fill_zero = (fill_ff == '0);
   assign status.dump_last = (dump_cnt_ff == CNT_W'(1));

   assign rsp_valid         = valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_id    = ev_id_ff;
   assign rsp_entry_valid   = en_valid_ff;
   assign rsp_entry_id      = en_id_ff;
   assign rsp_held_count    = count_ff;
   assign rsp_last_of_run   = last_ff;
   assign cfg_capacity      = capacity_ff;

endmodule

FILE: rtl/fifo_replacement_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_replacement_cache_unit
// Fully associative identifier store with first-in-first-out replacement.
// ----------------------------------------------------------------------------
// An access request looks its identifier up in all live entries at once and
// produces one result in the following cycle, so back-to-back accesses run at
// one transfer per cycle while results are taken. A dump of n entries starts
// with a start step and then emits one entry per result, newest first, because the
// entries are read through a single read port; the store is empty afterward.
// No request is accepted while a dump is in progress. The capacity register
// lies at byte address 0 and should only be written while the unit is idle.
module fifo_replacement_cache_unit #(
   parameter int MAX_ENTRIES = frc_pkg::MAX_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [frc_pkg::ID_W-1:0]            req_friend_id,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic                                rsp_evicted_valid,
   output logic [frc_pkg::ID_W-1:0]            rsp_evicted_id,
   output logic                                rsp_entry_valid,
   output logic [frc_pkg::ID_W-1:0]            rsp_entry_id,
   output logic [frc_pkg::CAP_W-1:0]           rsp_held_count,
   output logic                                rsp_last_of_run,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [frc_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [frc_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [frc_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import frc_pkg::*;

   frc_cmd_type    cmd;
   frc_status_type status;
   logic           cfg_write;
   logic [CAP_W-1:0] capacity;

   // The address space holds only the capacity register.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && (paddr == CSR_CAPACITY_ADDR);
   assign prdata    = CSR_DATA_W'(capacity);

   frc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd)
   );

   frc_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_friend_id     (req_friend_id),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_id    (rsp_evicted_id),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_entry_id      (rsp_entry_id),
      .rsp_held_count    (rsp_held_count),
      .rsp_last_of_run   (rsp_last_of_run),
      .cfg_write         (cfg_write),
      .cfg_wdata         (pwdata[CAP_W-1:0]),
      .cfg_capacity      (capacity)
   );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FIFO replacement cache unit.
// ----------------------------------------------------------------------------
// Requests are sent in random bursts while the result side stalls on its own
// pattern. A model of the identifier store, kept here, predicts every result
// at the moment its request transfer completes, and a checker compares each
// result transfer with the oldest prediction. Directed cases cover empty dumps,
// extreme identifiers, small and out-of-range capacities, and a capacity
// lowered below the held count. Random traffic then runs at several capacity
// settings, and one long result stall fills the unit so that it blocks input.
// ----------------------------------------------------------------------------
module tb;
   import frc_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 4;
   localparam int ITEMS_PER_PHASE = 45;
   localparam int PEND_DEPTH = 64;

   typedef struct packed {
      logic              hit;
      logic              evicted_valid;
      logic [ID_W-1:0]   evicted_id;
      logic              entry_valid;
      logic [ID_W-1:0]   entry_id;
      logic [CAP_W-1:0]  held_count;
      logic              last_of_run;
   } cache_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = ACT_ACCESS;
   logic [ID_W-1:0] req_friend_id = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;
   logic rsp_evicted_valid;
   logic [ID_W-1:0] rsp_evicted_id;
   logic rsp_entry_valid;
   logic [ID_W-1:0] rsp_entry_id;
   logic [CAP_W-1:0] rsp_held_count;
   logic rsp_last_of_run;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   logic [ID_W-1:0] store_ids [MAX_ENTRIES_DEF];
   logic [3:0] store_oldest = '0;
   int store_fill = 0;
   logic [CAP_W-1:0] store_capacity = CAPACITY_RESET;
   cache_result_type pending_results [PEND_DEPTH];
   int pend_wr = 0;
   int pend_rd = 0;

   int error_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   bit gaps_enabled = 1'b1;
   int holdoff_left = 0;
   int stall_mode = 0;
   int stall_tick = 0;

   fifo_replacement_cache_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_friend_id(req_friend_id),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit),
      .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_id(rsp_evicted_id),
      .rsp_entry_valid(rsp_entry_valid),
      .rsp_entry_id(rsp_entry_id),
      .rsp_held_count(rsp_held_count),
      .rsp_last_of_run(rsp_last_of_run),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic string fmt_result(cache_result_type r);
      return $sformatf("hit=%0d ev=%0d ev_id=%h en=%0d en_id=%h count=%0d last=%0d",
                       r.hit, r.evicted_valid, r.evicted_id, r.entry_valid,
                       r.entry_id, r.held_count, r.last_of_run);
   endfunction

   function automatic int pending_count();
      return pend_wr - pend_rd;
   endfunction

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   task automatic add_expected(cache_result_type r);
      pending_results[pend_wr % PEND_DEPTH] = r;
      pend_wr++;
   endtask

   task automatic predict_cache(logic action, logic [ID_W-1:0] id);
      cache_result_type r;
      logic found;
      logic [3:0] slot;
      int limit;
      int k;
      r = '0;
      if (action == ACT_ACCESS) begin
         found = 1'b0;
         for (k = 0; k < store_fill; k++) begin
            slot = store_oldest + k[3:0];
            if (store_ids[slot] == id) begin
               found = 1'b1;
            end
         end
         if (!found) begin
            limit = (store_capacity == 0) ? 1 :
                    (store_capacity > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF :
                    int'(store_capacity);
            slot = store_oldest + store_fill[3:0];
            if (store_fill >= limit) begin
               r.evicted_valid = 1'b1;
               r.evicted_id = store_ids[store_oldest];
               store_ids[slot] = id;
               store_oldest = store_oldest + 4'd1;
            end else begin
               store_ids[slot] = id;
               store_fill++;
            end
         end
         r.hit = found;
         r.held_count = store_fill[CAP_W-1:0];
         r.last_of_run = 1'b1;
         add_expected(r);
      end else if (store_fill == 0) begin
         r.last_of_run = 1'b1;
         add_expected(r);
         store_oldest = '0;
      end else begin
         for (k = store_fill; k > 0; k--) begin
            slot = store_oldest + k[3:0] - 4'd1;
            r.entry_valid = 1'b1;
            r.entry_id = store_ids[slot];
            r.held_count = store_fill[CAP_W-1:0];
            r.last_of_run = (k == 1);
            add_expected(r);
         end
         store_fill = 0;
         store_oldest = '0;
      end
   endtask

   always @(posedge clock) begin
      cache_result_type got;
      cache_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_hit, rsp_evicted_valid, rsp_evicted_id, rsp_entry_valid,
                 rsp_entry_id, rsp_held_count, rsp_last_of_run};
         if (pending_count() == 0) begin
            report_error($sformatf("unexpected result: %s", fmt_result(got)));
         end else begin
            want = pending_results[pend_rd % PEND_DEPTH];
            pend_rd++;
            if (got !== want) begin
               report_error($sformatf("expected %s, got %s",
                                      fmt_result(want), fmt_result(got)));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         holdoff_left = holdoff_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         stall_tick++;
         if (stall_tick % 128 == 0) begin
            stall_mode = $urandom_range(0, 3);
         end
         case (stall_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_ready <= (stall_tick % 4) != 3;
            end
            default: begin
               rsp_ready <= $urandom_range(0, 7) != 0;
            end
         endcase
      end
   end

   task automatic send_item(logic action, logic [ID_W-1:0] id);
      if (gaps_enabled && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_friend_id <= id;
      do begin
         @(posedge clock);
      end while (!req_ready);
      predict_cache(action, id);
   endtask

   task automatic access(logic [ID_W-1:0] id);
      send_item(ACT_ACCESS, id);
   endtask

   task automatic dump();
      send_item(ACT_DUMP, $urandom);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_count() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      wait_quiet();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_CAPACITY_ADDR;
      pwdata <= {{(CSR_DATA_W-CAP_W){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      store_capacity = value;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      if (prdata[CAP_W-1:0] !== value) begin
         report_error($sformatf("capacity read back %h, expected %h",
                                prdata[CAP_W-1:0], value));
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_empty_and_extreme_ids();
      dump();
      access('0);
      access('1);
      access('0);
      access(32'hA5A5_5A5A);
      access(32'h5A5A_A5A5);
      dump();
   endtask

   task automatic test_small_capacity_eviction();
      write_capacity(5'd2);
      access(32'd1);
      access(32'd2);
      access(32'd3);
      access(32'd2);
      dump();
      write_capacity(5'd0);
      access(32'd7);
      access(32'd8);
      dump();
   endtask

   task automatic test_capacity_lowered();
      write_capacity(5'd16);
      access(32'd10);
      access(32'd11);
      access(32'd12);
      access(32'd13);
      write_capacity(5'd2);
      access(32'd14);
      access(32'd11);
      dump();
   endtask

   task automatic run_random_phase(logic [CAP_W-1:0] cap, int count);
      logic [ID_W-1:0] base;
      int span;
      int n;
      write_capacity(cap);
      base = $urandom;
      span = (cap == 0) ? 3 : (cap > MAX_ENTRIES_DEF) ? 34 : 2 * int'(cap) + 2;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 11) == 0) begin
            dump();
         end else if ($urandom_range(0, 7) == 0) begin
            access($urandom);
         end else begin
            access(base + $urandom_range(0, span));
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(5'd1, ITEMS_PER_PHASE);
      run_random_phase(5'd16, ITEMS_PER_PHASE);
      gaps_enabled = 1'b0;
      run_random_phase(5'd31, ITEMS_PER_PHASE);
      gaps_enabled = 1'b1;
      run_random_phase(5'd0, ITEMS_PER_PHASE);
      run_random_phase(5'($urandom_range(2, 15)), ITEMS_PER_PHASE);
      run_random_phase(5'($urandom_range(17, 30)), ITEMS_PER_PHASE);
   endtask

   task automatic test_result_backpressure();
      int n;
      write_capacity(5'd16);
      gaps_enabled = 1'b0;
      holdoff_left = 300;
      for (n = 0; n < 20; n++) begin
         access($urandom);
      end
      dump();
      for (n = 0; n < 8; n++) begin
         access($urandom_range(0, 3));
      end
      dump();
      gaps_enabled = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_extreme_ids();
      test_small_capacity_eviction();
      test_capacity_lowered();
      test_random_traffic();
      test_result_backpressure();
      wait_quiet();
      repeat (20) @(posedge clock);
      if (pending_count() != 0) begin
         report_error($sformatf("%0d results never arrived", pending_count()));
      end
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
